FILE: design/unv_pkg.sv
`timescale 1ns / 1ps

package unv_pkg;

  // Item kinds carried on the input tuser field.
  typedef enum logic [1:0] {
    OP_DATA    = 2'd0,
    OP_END     = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Decoder modes.
  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_SLASH = 3'd1,
    MODE_OCTAL = 3'd2,
    MODE_M     = 3'd3,
    MODE_C     = 3'd4,
    MODE_MD    = 3'd5,
    MODE_MC    = 3'd6
  } mode_t;

  // Characters that steer the escape decoding.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  // Results that one item produces: up to two bytes.
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } dec_res_t;

endpackage

FILE: design/unv_core.sv
`timescale 1ns / 1ps

module unv_core import unv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  op_t        opcode,
  input  logic [7:0] in_byte,
  output dec_res_t   res
);

  mode_t      mode_r, mode_nxt;
  logic [1:0] dcnt_r, dcnt_nxt;
  logic [7:0] oct_r, oct_nxt;

  logic       is_oct;
  logic [7:0] oct_v;

  assign is_oct = (in_byte[7:3] == 5'b00110);
  // Shift in one octal digit; bits above bit 7 fall off.
  assign oct_v  = {oct_r[4:0], in_byte[2:0]};

  // Next state and results for the item at the head of the pipe.
  always_comb begin
    mode_nxt = mode_r;
    dcnt_nxt = dcnt_r;
    oct_nxt  = oct_r;
    res.cnt  = 2'd0;
    res.b0   = 8'h00;
    res.b1   = 8'h00;
    unique case (opcode)
      OP_DATA: begin
        unique case (mode_r)
          MODE_START: begin
            if (in_byte == CH_BSLASH) begin
              mode_nxt = MODE_SLASH;
            end else begin
              res.cnt = 2'd1;
              res.b0  = in_byte;
            end
          end
          MODE_SLASH: begin
            mode_nxt = MODE_START;
            if (is_oct) begin
              mode_nxt = MODE_OCTAL;
              dcnt_nxt = 2'd1;
              oct_nxt  = {5'd0, in_byte[2:0]};
            end else if (in_byte == CH_M) begin
              mode_nxt = MODE_M;
            end else if (in_byte == CH_CARET) begin
              mode_nxt = MODE_C;
            end else begin
              res.cnt = 2'd1;
              unique case (in_byte)
                8'h61:     res.b0 = 8'h07;
                8'h62:     res.b0 = 8'h08;
                8'h66:     res.b0 = 8'h0C;
                8'h6E:     res.b0 = 8'h0A;
                8'h72:     res.b0 = 8'h0D;
                8'h73:     res.b0 = 8'h20;
                8'h74:     res.b0 = 8'h09;
                8'h76:     res.b0 = 8'h0B;
                CH_BSLASH: res.b0 = CH_BSLASH;
                default:   res.cnt = 2'd0;
              endcase
            end
          end
          MODE_OCTAL: begin
            if (is_oct) begin
              if (dcnt_r >= 2'd2) begin
                // Third digit completes the value.
                mode_nxt = MODE_START;
                dcnt_nxt = 2'd0;
                oct_nxt  = 8'h00;
                res.cnt  = 2'd1;
                res.b0   = oct_v;
              end else begin
                dcnt_nxt = dcnt_r + 2'd1;
                oct_nxt  = oct_v;
              end
            end else begin
              // A non-digit ends the value, then decodes from plain text.
              dcnt_nxt = 2'd0;
              oct_nxt  = 8'h00;
              res.b0   = oct_r;
              if (in_byte == CH_BSLASH) begin
                mode_nxt = MODE_SLASH;
                res.cnt  = 2'd1;
              end else begin
                mode_nxt = MODE_START;
                res.cnt  = 2'd2;
                res.b1   = in_byte;
              end
            end
          end
          MODE_M: begin
            if (in_byte == CH_CARET) begin
              mode_nxt = MODE_MC;
            end else if (in_byte == CH_DASH) begin
              mode_nxt = MODE_MD;
            end else begin
              mode_nxt = MODE_START;
            end
          end
          MODE_MD: begin
            mode_nxt = MODE_START;
            if (in_byte >= 8'h21 && in_byte <= 8'h7E) begin
              res.cnt = 2'd1;
              res.b0  = {1'b1, in_byte[6:0]};
            end
          end
          MODE_C, MODE_MC: begin
            mode_nxt = MODE_START;
            if (in_byte == CH_QMARK) begin
              res.cnt = 2'd1;
              res.b0  = {mode_r == MODE_MC, CH_DEL[6:0]};
            end else if (in_byte >= 8'h40 && in_byte <= 8'h7E) begin
              // Both letter ranges drop to the low five bits.
              res.cnt = 2'd1;
              res.b0  = {mode_r == MODE_MC, 2'b00, in_byte[4:0]};
            end
          end
          default: begin
            mode_nxt = MODE_START;
            dcnt_nxt = 2'd0;
            oct_nxt  = 8'h00;
          end
        endcase
      end
      OP_END: begin
        if (mode_r == MODE_OCTAL) begin
          res.cnt = 2'd1;
          res.b0  = oct_r;
        end
        mode_nxt = MODE_START;
        dcnt_nxt = 2'd0;
        oct_nxt  = 8'h00;
      end
      OP_RESTART: begin
        mode_nxt = MODE_START;
        dcnt_nxt = 2'd0;
        oct_nxt  = 8'h00;
      end
      OP_NONE: begin
        mode_nxt = mode_r;
      end
    endcase
  end

  // Decoder state advances only when the item is retired.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_START;
      dcnt_r <= 2'd0;
      oct_r  <= 8'h00;
    end else if (step) begin
      mode_r <= mode_nxt;
      dcnt_r <= dcnt_nxt;
      oct_r  <= oct_nxt;
    end
  end

  a_dcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_OCTAL) |-> (dcnt_r == 2'd1 || dcnt_r == 2'd2))
    else $error("octal digit count out of range");

  a_clear_outside_octal: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_OCTAL) |-> (dcnt_r == 2'd0 && oct_r == 8'h00))
    else $error("octal state left over outside octal mode");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && opcode == OP_RESTART) |=> (mode_r == MODE_START))
    else $error("restart did not clear the decoder");

endmodule

FILE: design/unvis_escape_decoder.sv
`timescale 1ns / 1ps
// Path: an input beat passes the input register, then the two-entry result buffer that
//   drives the output.
// Throughput: one input beat per cycle while the result buffer has room; an item that
//   yields two bytes leaves one byte at a time through the single output port.
// Reset: synchronous, active low rst_n; decoder returns to plain text, buffers empty.
module unvis_escape_decoder import unv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic [1:0] in_tuser,   // [1:0] opcode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);

  // Input register.
  logic       iv_r;
  op_t        op_r;
  logic [7:0] byte_r;

  // Two-entry result buffer, entry 0 is the head.
  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] e0_b_r, e0_b_nxt, e1_b_r, e1_b_nxt;
  logic       e0_l_r, e0_l_nxt, e1_l_r, e1_l_nxt;

  dec_res_t   res;
  logic       pop, proc;
  logic [1:0] cnt_left;
  logic [2:0] need;

  unv_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (proc),
    .opcode  (op_r),
    .in_byte (byte_r),
    .res     (res)
  );

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = e0_b_r;
  assign out_tlast  = e0_l_r;
  assign pop        = out_tvalid && out_tready;

  // The held item retires once its results fit behind what is left.
  assign cnt_left  = cnt_r - {1'b0, pop};
  assign need      = {1'b0, cnt_left} + {1'b0, res.cnt};
  assign proc      = iv_r && (need <= 3'd2);
  assign in_tready = !iv_r || proc;

  // Buffer update: shift out the head, then append the new results.
  always_comb begin
    e0_b_nxt = pop ? e1_b_r : e0_b_r;
    e0_l_nxt = pop ? e1_l_r : e0_l_r;
    e1_b_nxt = e1_b_r;
    e1_l_nxt = e1_l_r;
    cnt_nxt  = cnt_left;
    if (proc) begin
      cnt_nxt = need[1:0];
      if (res.cnt == 2'd2) begin
        e0_b_nxt = res.b0;
        e0_l_nxt = 1'b0;
        e1_b_nxt = res.b1;
        e1_l_nxt = 1'b1;
      end else if (res.cnt == 2'd1) begin
        if (cnt_left == 2'd0) begin
          e0_b_nxt = res.b0;
          e0_l_nxt = 1'b1;
        end else begin
          e1_b_nxt = res.b0;
          e1_l_nxt = 1'b1;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_tready) begin
        iv_r <= in_tvalid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op_r   <= op_t'(in_tuser);
      byte_r <= in_tdata;
    end
    e0_b_r <= e0_b_nxt;
    e0_l_r <= e0_l_nxt;
    e1_b_r <= e1_b_nxt;
    e1_l_r <= e1_l_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer overflow");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop && res.cnt != 2'd0) |-> !proc)
    else $error("item retired into a full buffer");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && res.cnt == 2'd2) |=> (out_tvalid && !out_tlast && cnt_r == 2'd2))
    else $error("two-byte result not queued in order");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (iv_r && !proc) |=> (iv_r && $stable(byte_r) && $stable(op_r)))
    else $error("held item lost while stalled");

endmodule

FILE: verif/tb_unvis_escape_decoder.sv
`timescale 1ns / 1ps

module tb_unvis_escape_decoder;
  import unv_pkg::*;

  localparam int ITEMS_PER_PHASE = 440;
  localparam int HOLD_CYCLES     = 300;
  localparam int QUIET_LIMIT     = 5000;
  localparam int TAIL_CYCLES     = 10;

  // One input beat, with an optional hand-written expectation.
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       typed;
    dec_res_t   want;
  } beat_t;

  // One decoded byte as it should leave the block.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_byte_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] in_byte
  logic [1:0] in_tuser   = 2'd0;   // [1:0] opcode
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] out_byte
  logic       out_tlast;

  // Decoder state as predicted.
  mode_t      dec_mode = MODE_START;
  logic [1:0] dig_cnt  = 2'd0;
  logic [7:0] oct_val  = 8'h00;

  beat_t     run_q[$];
  beat_t     sent_q[$];
  dec_byte_t decoded_q[$];

  int err_cnt        = 0;
  int beats_sent     = 0;
  int beats_ignored  = 0;
  int bytes_checked  = 0;
  int two_byte_beats = 0;
  int src_idle_pct   = 0;
  int snk_stall_pct  = 0;
  int hold_req_cnt   = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  // Directed beats: extremes, each escape family, octal cut short, end, restart
  // and the unused opcode.
  beat_t dir_tab [28] = '{
    '{OP_DATA,    8'h00,     1'b1, '{2'd1, 8'h00, 8'h00}},
    '{OP_DATA,    8'hFF,     1'b1, '{2'd1, 8'hFF, 8'h00}},
    '{OP_DATA,    CH_BSLASH, 1'b1, '{2'd0, 8'h00, 8'h00}},
    '{OP_DATA,    "n",       1'b1, '{2'd1, 8'h0A, 8'h00}},
    '{OP_DATA,    CH_BSLASH, 1'b1, '{2'd0, 8'h00, 8'h00}},
    '{OP_DATA,    "7",       1'b1, '{2'd0, 8'h00, 8'h00}},
    '{OP_DATA,    "7",       1'b1, '{2'd0, 8'h00, 8'h00}},
    '{OP_DATA,    "7",       1'b1, '{2'd1, 8'hFF, 8'h00}},
    '{OP_DATA,    CH_BSLASH, 1'b0, '0},
    '{OP_DATA,    "4",       1'b0, '0},
    '{OP_DATA,    "A",       1'b0, '0},
    '{OP_DATA,    CH_BSLASH, 1'b0, '0},
    '{OP_DATA,    CH_M,      1'b0, '0},
    '{OP_DATA,    CH_DASH,   1'b0, '0},
    '{OP_DATA,    "A",       1'b1, '{2'd1, 8'hC1, 8'h00}},
    '{OP_DATA,    CH_BSLASH, 1'b0, '0},
    '{OP_DATA,    CH_M,      1'b0, '0},
    '{OP_DATA,    CH_CARET,  1'b0, '0},
    '{OP_DATA,    CH_QMARK,  1'b1, '{2'd1, 8'hFF, 8'h00}},
    '{OP_DATA,    CH_BSLASH, 1'b1, '{2'd0, 8'h00, 8'h00}},
    '{OP_DATA,    8'h80,     1'b1, '{2'd0, 8'h00, 8'h00}},
    '{OP_DATA,    CH_BSLASH, 1'b0, '0},
    '{OP_DATA,    "5",       1'b0, '0},
    '{OP_END,     8'hA5,     1'b1, '{2'd1, 8'h05, 8'h00}},
    '{OP_DATA,    CH_BSLASH, 1'b1, '{2'd0, 8'h00, 8'h00}},
    '{OP_RESTART, 8'h5A,     1'b1, '{2'd0, 8'h00, 8'h00}},
    '{OP_NONE,    8'hFF,     1'b1, '{2'd0, 8'h00, 8'h00}},
    '{OP_DATA,    "n",       1'b1, '{2'd1, 8'h6E, 8'h00}}
  };

  unvis_escape_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_decoder();
    dec_mode = MODE_START;
    dig_cnt  = 2'd0;
    oct_val  = 8'h00;
  endfunction

  function automatic void add_byte(inout dec_res_t r, input logic [7:0] b);
    if (r.cnt == 2'd0) r.b0 = b;
    else r.b1 = b;
    r.cnt = r.cnt + 2'd1;
  endfunction

  // Predicts the bytes one input beat yields and advances the decoder state.
  function automatic dec_res_t unvis_step(op_t op, logic [7:0] c);
    dec_res_t   r;
    logic [7:0] v;
    logic [7:0] off;
    logic       digit;
    r     = '0;
    digit = (c >= "0") && (c <= "7");
    case (op)
      OP_DATA: begin
        // A non-digit closes a pending octal value; the byte is then read as plain text.
        if (dec_mode == MODE_OCTAL && !digit) begin
          add_byte(r, oct_val);
          clear_decoder();
        end
        case (dec_mode)
          MODE_START: begin
            if (c == CH_BSLASH) dec_mode = MODE_SLASH;
            else add_byte(r, c);
          end
          MODE_SLASH: begin
            dec_mode = MODE_START;
            if (digit) begin
              dec_mode = MODE_OCTAL;
              dig_cnt  = 2'd1;
              oct_val  = c - "0";
            end else if (c == CH_M) begin
              dec_mode = MODE_M;
            end else if (c == CH_CARET) begin
              dec_mode = MODE_C;
            end else begin
              case (c)
                "a":       add_byte(r, 8'h07);
                "b":       add_byte(r, 8'h08);
                "f":       add_byte(r, 8'h0C);
                "n":       add_byte(r, 8'h0A);
                "r":       add_byte(r, 8'h0D);
                "s":       add_byte(r, 8'h20);
                "t":       add_byte(r, 8'h09);
                "v":       add_byte(r, 8'h0B);
                CH_BSLASH: add_byte(r, CH_BSLASH);
                default: ;
              endcase
            end
          end
          MODE_OCTAL: begin
            // Bits shifted past bit 7 fall away; the third digit emits at once.
            v = {oct_val[4:0], c[2:0]};
            if (dig_cnt >= 2'd2) begin
              clear_decoder();
              add_byte(r, v);
            end else begin
              dig_cnt = dig_cnt + 2'd1;
              oct_val = v;
            end
          end
          MODE_M: begin
            if (c == CH_CARET) dec_mode = MODE_MC;
            else if (c == CH_DASH) dec_mode = MODE_MD;
            else dec_mode = MODE_START;
          end
          MODE_MD: begin
            dec_mode = MODE_START;
            if (c >= 8'h21 && c <= 8'h7E) add_byte(r, c + 8'h80);
          end
          MODE_C, MODE_MC: begin
            off      = (dec_mode == MODE_MC) ? 8'h80 : 8'h00;
            dec_mode = MODE_START;
            if (c == CH_QMARK) add_byte(r, CH_DEL + off);
            else if (c >= 8'h40 && c <= 8'h5F) add_byte(r, c - 8'h40 + off);
            else if (c >= 8'h60 && c <= 8'h7E) add_byte(r, c - 8'h60 + off);
          end
          default: clear_decoder();
        endcase
      end
      OP_END: begin
        if (dec_mode == MODE_OCTAL) add_byte(r, oct_val);
        clear_decoder();
      end
      OP_RESTART: clear_decoder();
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_beat(op_t op, logic [7:0] d);
    run_q.push_back('{op, d, 1'b0, '0});
  endfunction

  // Builds one short run of beats, mostly well-formed escapes with random content.
  function automatic void build_run();
    string esc_letters;
    int    pick;
    esc_letters = "abfnrstv\\";
    pick        = $urandom_range(99);
    if (pick < 15) begin
      add_beat(OP_DATA, 8'($urandom));
    end else if (pick < 30) begin
      add_beat(OP_DATA, CH_BSLASH);
      add_beat(OP_DATA, esc_letters[$urandom_range(8)]);
    end else if (pick < 50) begin
      // One to three octal digits, then maybe a terminator: a random byte, an end or a printable byte.
      add_beat(OP_DATA, CH_BSLASH);
      repeat ($urandom_range(1, 3)) add_beat(OP_DATA, "0" + 8'($urandom_range(7)));
      case ($urandom_range(3))
        0: ;
        1: add_beat(OP_DATA, 8'($urandom));
        2: add_beat(OP_END, 8'($urandom));
        default: add_beat(OP_DATA, 8'($urandom_range(8'h7E, 8'h20)));
      endcase
    end else if (pick < 60) begin
      // Meta escapes with a dash, mostly on graphic bytes.
      add_beat(OP_DATA, CH_BSLASH);
      add_beat(OP_DATA, CH_M);
      add_beat(OP_DATA, CH_DASH);
      if ($urandom_range(3) == 0) add_beat(OP_DATA, 8'($urandom));
      else add_beat(OP_DATA, 8'($urandom_range(8'h7E, 8'h21)));
    end else if (pick < 75) begin
      // Control escapes, with or without the meta prefix.
      add_beat(OP_DATA, CH_BSLASH);
      if ($urandom_range(1) == 1) add_beat(OP_DATA, CH_M);
      add_beat(OP_DATA, CH_CARET);
      case ($urandom_range(3))
        0: add_beat(OP_DATA, CH_QMARK);
        1: add_beat(OP_DATA, 8'($urandom_range(8'h5F, 8'h40)));
        2: add_beat(OP_DATA, 8'($urandom_range(8'h7E, 8'h60)));
        default: add_beat(OP_DATA, 8'($urandom));
      endcase
    end else if (pick < 82) begin
      // A prefix cut short by an end or a restart.
      add_beat(OP_DATA, CH_BSLASH);
      case ($urandom_range(2))
        0: ;
        1: add_beat(OP_DATA, CH_M);
        default: add_beat(OP_DATA, CH_CARET);
      endcase
      add_beat(($urandom_range(1) == 1) ? OP_END : OP_RESTART, 8'($urandom));
    end else if (pick < 92) begin
      // Malformed: an escape prefix followed by an arbitrary byte.
      add_beat(OP_DATA, CH_BSLASH);
      if ($urandom_range(1) == 1) add_beat(OP_DATA, CH_M);
      add_beat(OP_DATA, 8'($urandom));
    end else begin
      add_beat(op_t'($urandom_range(3)), 8'($urandom));
    end
  endfunction

  // Offers one beat after a random number of idle cycles and waits for its handshake.
  task automatic drive_beat(input beat_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tuser  <= 2'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b.data;
    in_tuser  <= b.op;
    sent_q.push_back(b);
    beats_sent++;
    if (b.op == OP_NONE) beats_ignored++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Result receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_seen != hold_req_cnt) begin
      hold_seen  <= hold_req_cnt;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Predict on every accepted input beat and check every accepted result beat.
  always @(posedge clk) begin : scoreboard
    beat_t     sent;
    dec_res_t  got;
    dec_byte_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sent = sent_q.pop_front();
        got  = unvis_step(op_t'(in_tuser), in_tdata);
        if (sent.typed) got = sent.want;
        if (got.cnt == 2'd2) two_byte_beats++;
        if (got.cnt != 2'd0) decoded_q.push_back('{got.b0, got.cnt == 2'd1});
        if (got.cnt == 2'd2) decoded_q.push_back('{got.b1, 1'b1});
      end
      if (out_tvalid && out_tready) begin
        bytes_checked++;
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result beat, actual byte %h last %b",
                   $time, out_tdata, out_tlast);
          err_cnt++;
        end else begin
          want = decoded_q.pop_front();
          if (out_tdata !== want.data) begin
            $display("%0t: byte mismatch, expected %h actual %h", $time, want.data, out_tdata);
            err_cnt++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: last mismatch, expected %b actual %b", $time, want.last, out_tlast);
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout after %0d cycles without a beat", $time, QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int    phase;
    int    count;
    beat_t b;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats first, with no idling on either side.
    foreach (dir_tab[i]) drive_beat(dir_tab[i]);

    // Random runs under four flow-control regimes.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle_pct   = 0;
          snk_stall_pct <= 0;
          hold_req_cnt  <= hold_req_cnt + 1;
        end
        1: begin
          src_idle_pct   = 63;
          snk_stall_pct <= 0;
        end
        2: begin
          src_idle_pct   = 0;
          snk_stall_pct <= 63;
        end
        default: begin
          src_idle_pct   = 13;
          snk_stall_pct <= 13;
        end
      endcase
      count = 0;
      while (count < ITEMS_PER_PHASE) begin
        build_run();
        while (run_q.size() != 0) begin
          b = run_q.pop_front();
          drive_beat(b);
          if (b.op != OP_NONE) count++;
        end
      end
    end

    // Drain the expected bytes, then give the block time to show any extra beat.
    in_tvalid     <= 1'b0;
    snk_stall_pct <= 0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d input beats (%0d with the unused opcode) in four flow-control phases,",
             beats_sent, beats_ignored);
    $display("with one long output hold; checked %0d decoded bytes, %0d beats gave two bytes.",
             bytes_checked, two_byte_beats);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
